>>> rtl/core/wsfd_pkg.sv
// ---------------------------------------------------------------------------
// wsfd_pkg
// shared types, protocol constants and helpers for the wheel speed frame decoder
// ---------------------------------------------------------------------------
package wsfd_pkg;

   // frame layout
   localparam logic [3:0] HDR_LEN          = 4'd3;
   localparam logic [3:0] LAST_POS         = 4'd15;
   localparam logic [3:0] POS_SPEED_A_HI   = 4'd8;
   localparam logic [3:0] POS_SPEED_A_LO   = 4'd9;
   localparam logic [3:0] POS_SPEED_B_HI   = 4'd10;
   localparam logic [3:0] POS_SPEED_B_LO   = 4'd11;
   localparam logic [3:0] POS_DIRECTION    = 4'd12;
   localparam logic [3:0] POS_SERVO_HI     = 4'd13;
   localparam logic [3:0] POS_SERVO_LO     = 4'd14;

   // xor check span: positions CHECK_START .. CHECK_END-1 against CHECK_END
   localparam logic [3:0] CHECK_START      = 4'd3;
   localparam logic [3:0] CHECK_END        = 4'd15;

   // header bytes
   localparam logic [7:0] HDR_BYTE0        = 8'hFF;
   localparam logic [7:0] HDR_BYTE1        = 8'hFE;
   localparam logic [7:0] HDR_BYTE2        = 8'h65;

   // direction codes
   localparam logic [7:0] DIR_FORWARD      = 8'h05;
   localparam logic [7:0] DIR_REVERSE      = 8'h0A;

   // motion codes on the result
   localparam logic [1:0] MOTION_STOP      = 2'd0;
   localparam logic [1:0] MOTION_FORWARD   = 2'd1;
   localparam logic [1:0] MOTION_REVERSE   = 2'd2;

   // one completed frame, as handed from the parser to the result stage
   typedef struct packed {
      logic        ok;
      logic [15:0] speed_a;
      logic [15:0] speed_b;
      logic [7:0]  direction;
      logic [15:0] servo;
   } frame_type;

   // expected header byte at hunt position 0..2
   function automatic logic [7:0] header_byte(input logic [1:0] pos);
      logic [7:0] hb;
      unique case (pos)
         2'd0:    hb = HDR_BYTE0;
         2'd1:    hb = HDR_BYTE1;
         default: hb = HDR_BYTE2;
      endcase
      return hb;
   endfunction

   // signed speed after the direction is applied, reverse of -32768 saturates
   function automatic logic signed [15:0] apply_dir(input logic [15:0] raw,
                                                    input logic [1:0]  motion);
      logic signed [15:0] s;
      unique case (motion)
         MOTION_FORWARD: s = raw;
         MOTION_REVERSE: s = (raw == 16'h8000) ? 16'sh7FFF : 16'(~raw + 16'd1);
         default:        s = 16'sd0;
      endcase
      return s;
   endfunction

endpackage

>>> rtl/core/wheel_speed_frame_decoder_core.sv
// ---------------------------------------------------------------------------
// wheel_speed_frame_decoder_core
// decodes the motor controller reply stream into signed wheel speeds
//
// throughput: one byte per cycle, sustained while the result side keeps up
// result path: frame register in the parser, then the result register
// reset: synchronous, returns to header hunt and drops any pending result
// ---------------------------------------------------------------------------
module wheel_speed_frame_decoder_core (
   input  logic               clock,
   input  logic               reset,
   // byte input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_frame_ok,
   output logic signed [15:0] rsp_left_speed,
   output logic signed [15:0] rsp_right_speed,
   output logic signed [16:0] rsp_linear_speed_sum,
   output logic [15:0]        rsp_servo_angle_raw,
   output logic [1:0]         rsp_motion
);
   import wsfd_pkg::*;

   logic               req_accept;
   logic               frame_valid;
   frame_type          frame;
   logic               out_load;
   logic               advance;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               ok_ff,        ok_in;
   logic signed [15:0] left_ff,      left_in;
   logic signed [15:0] right_ff,     right_in;
   logic signed [16:0] sum_ff,       sum_in;
   logic [15:0]        servo_ff,     servo_in;
   logic [1:0]         motion_ff,    motion_in;

   // result register can take a new value when empty or being drained
   assign out_load   = !rsp_valid_ff || !rsp_stall;
   // the finished frame moves into the result register
   assign advance    = frame_valid && out_load;
   // only a frame stuck behind a stalled result holds off new bytes
   assign req_stall  = frame_valid && !out_load;
   assign req_accept = req_valid && !req_stall;

   wsfd_frame_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .rx_byte     (req_rx_byte),
      .advance     (advance),
      .frame_valid (frame_valid),
      .frame       (frame)
   );

   // direction decode, sign handling and sum; all zero on a failed check
   always_comb begin
      ok_in     = frame.ok;
      motion_in = MOTION_STOP;
      left_in   = 16'sd0;
      right_in  = 16'sd0;
      sum_in    = 17'sd0;
      servo_in  = 16'd0;
      if (frame.ok) begin
         priority if (frame.direction == DIR_FORWARD) begin
            motion_in = MOTION_FORWARD;
         end else if (frame.direction == DIR_REVERSE) begin
            motion_in = MOTION_REVERSE;
         end else begin
            motion_in = MOTION_STOP;
         end
         left_in  = apply_dir(frame.speed_a, motion_in);
         right_in = apply_dir(frame.speed_b, motion_in);
         // sign-extended add, linear speed in half mm/s
         sum_in   = {left_in[15], left_in} + {right_in[15], right_in};
         servo_in = frame.servo;
      end
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only on a frame transfer
   always_ff @(posedge clock) begin
      if (advance) begin
         ok_ff     <= ok_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
         sum_ff    <= sum_in;
         servo_ff  <= servo_in;
         motion_ff <= motion_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_frame_ok         = ok_ff;
   assign rsp_left_speed       = left_ff;
   assign rsp_right_speed      = right_ff;
   assign rsp_linear_speed_sum = sum_ff;
   assign rsp_servo_angle_raw  = servo_ff;
   assign rsp_motion           = motion_ff;

   // failed check gives an all-zero result
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !ok_ff |-> left_ff == 16'sd0 && right_ff == 16'sd0 &&
         sum_ff == 17'sd0 && servo_ff == 16'd0 && motion_ff == MOTION_STOP)
      else $error("failed frame with nonzero fields");

   // linear sum matches the two wheel speeds
   a_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> sum_ff == ({left_ff[15], left_ff} + {right_ff[15], right_ff}))
      else $error("linear sum mismatch");

   // stop means both wheels at zero
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && motion_ff == MOTION_STOP |-> left_ff == 16'sd0 && right_ff == 16'sd0)
      else $error("stop with nonzero speed");

   // input is only held off while a frame waits behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall && frame_valid)
      else $error("input stalled without cause");

endmodule

>>> rtl/core/wsfd_frame_parser.sv
// ---------------------------------------------------------------------------
// wsfd_frame_parser
// header hunt, 16-byte frame collection, xor check; holds one finished frame
// ---------------------------------------------------------------------------
module wsfd_frame_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          rx_byte,
   input  logic                advance,
   output logic                frame_valid,
   output wsfd_pkg::frame_type frame
);
   import wsfd_pkg::*;

   logic [3:0]  pos_ff,     pos_in;
   logic [7:0]  xor_ff,     xor_in;
   logic [15:0] speed_a_ff, speed_a_in;
   logic [15:0] speed_b_ff, speed_b_in;
   logic [7:0]  dir_ff,     dir_in;
   logic [15:0] servo_ff,   servo_in;
   logic        frame_valid_ff, frame_valid_in;
   frame_type   frame_ff,   frame_in;
   logic        xor_hit;
   logic        last_byte;

   assign xor_hit = (pos_ff == CHECK_START) ||
                    ((pos_ff > CHECK_START) && (pos_ff < CHECK_END)) ||
                    (pos_ff == CHECK_END);
   assign last_byte = accept && (pos_ff == LAST_POS);

   always_comb begin
      pos_in     = pos_ff;
      xor_in     = xor_ff;
      speed_a_in = speed_a_ff;
      speed_b_in = speed_b_ff;
      dir_in     = dir_ff;
      servo_in   = servo_ff;
      if (accept) begin
         if (pos_ff < HDR_LEN) begin
            if (rx_byte == header_byte(pos_ff[1:0])) begin
               pos_in = pos_ff + 4'd1;
               if (pos_ff == 4'd2) begin
                  xor_in = 8'd0;
               end
            end else begin
               // a stray 0xff may itself start the next header
               pos_in = (rx_byte == HDR_BYTE0) ? 4'd1 : 4'd0;
            end
         end else begin
            if (xor_hit) begin
               xor_in = xor_ff ^ rx_byte;
            end
            unique case (pos_ff)
               POS_SPEED_A_HI: speed_a_in = {rx_byte, speed_a_ff[7:0]};
               POS_SPEED_A_LO: speed_a_in = {speed_a_ff[15:8], rx_byte};
               POS_SPEED_B_HI: speed_b_in = {rx_byte, speed_b_ff[7:0]};
               POS_SPEED_B_LO: speed_b_in = {speed_b_ff[15:8], rx_byte};
               POS_DIRECTION:  dir_in     = rx_byte;
               POS_SERVO_HI:   servo_in   = {rx_byte, servo_ff[7:0]};
               POS_SERVO_LO:   servo_in   = {servo_ff[15:8], rx_byte};
               default: ;
            endcase
            pos_in = (pos_ff == LAST_POS) ? 4'd0 : pos_ff + 4'd1;
         end
      end
   end

   always_comb begin
      frame_in.ok        = (xor_in == 8'd0);
      frame_in.speed_a   = speed_a_ff;
      frame_in.speed_b   = speed_b_ff;
      frame_in.direction = dir_ff;
      frame_in.servo     = servo_ff;
      frame_valid_in     = (frame_valid_ff && !advance) || last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= 4'd0;
         xor_ff         <= 8'd0;
         speed_a_ff     <= 16'd0;
         speed_b_ff     <= 16'd0;
         dir_ff         <= 8'd0;
         servo_ff       <= 16'd0;
         frame_valid_ff <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         xor_ff         <= xor_in;
         speed_a_ff     <= speed_a_in;
         speed_b_ff     <= speed_b_in;
         dir_ff         <= dir_in;
         servo_ff       <= servo_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last_byte) begin
         frame_ff <= frame_in;
      end
   end

   assign frame_valid = frame_valid_ff;
   assign frame       = frame_ff;

   // a held frame is not overwritten while it waits
   a_frame_held: assert property (@(posedge clock) disable iff (reset)
      frame_valid_ff && !advance |=> frame_valid_ff && $stable(frame_ff))
      else $error("held frame changed");

   // only the last byte of a frame produces a frame
   a_no_early_frame: assert property (@(posedge clock) disable iff (reset)
      !frame_valid_ff && !(accept && pos_ff == LAST_POS) |=> !frame_valid_ff)
      else $error("frame without last byte");

   // reset returns to header hunt
   a_reset_hunt: assert property (@(posedge clock)
      reset |=> pos_ff == 4'd0 && !frame_valid_ff)
      else $error("reset did not restart hunt");

endmodule

>>> bench/wheel_frame_checker.sv
// ---------------------------------------------------------------------------
// wheel_frame_checker
// tracks every byte transfer into the wheel speed frame decoder, predicts the
// result of each completed frame and compares it field by field with the
// results that leave the block
// ---------------------------------------------------------------------------
module wheel_frame_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_frame_ok,
   input  logic signed [15:0] rsp_left_speed,
   input  logic signed [15:0] rsp_right_speed,
   input  logic signed [16:0] rsp_linear_speed_sum,
   input  logic [15:0]        rsp_servo_angle_raw,
   input  logic [1:0]         rsp_motion,
   output int                 mismatch_count,
   output int                 frames_pending,
   output int                 frames_checked
);
   import wsfd_pkg::*;

   typedef struct packed {
      logic        ok;
      logic [15:0] left_mms;
      logic [15:0] right_mms;
      logic [16:0] sum_half_mms;
      logic [15:0] servo;
      logic [1:0]  motion;
   } wheel_result_type;

   wheel_result_type expected_frames[$];

   // decoder state as the checker sees it
   logic [3:0]  frame_pos   = '0;
   logic [7:0]  xor_acc     = '0;
   logic [15:0] speed_a     = '0;
   logic [15:0] speed_b     = '0;
   logic [7:0]  dir_code    = '0;
   logic [15:0] servo_angle = '0;

   int errors    = 0;
   int outstanding = 0;
   int checked   = 0;

   assign mismatch_count = errors;
   assign frames_pending = outstanding;
   assign frames_checked = checked;

   function automatic logic [15:0] signed_with_direction(input logic [15:0] raw,
                                                         input logic [1:0]  motion);
      logic [15:0] speed;
      speed = '0;
      if (motion == MOTION_FORWARD) begin
         speed = raw;
      end else if (motion == MOTION_REVERSE) begin
         // most negative speed cannot be negated, clamp to the top
         speed = (raw == 16'h8000) ? 16'h7FFF : 16'h0000 - raw;
      end
      return speed;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch in %s (frame %0d): got %0d, expected %0d",
               what, checked, got, want);
      errors++;
   endtask

   task automatic predict_byte(input logic [7:0] b);
      logic [7:0]       hdr;
      logic [1:0]       motion;
      wheel_result_type res;
      if (frame_pos < HDR_LEN) begin
         case (frame_pos)
            4'd0:    hdr = HDR_BYTE0;
            4'd1:    hdr = HDR_BYTE1;
            default: hdr = HDR_BYTE2;
         endcase
         if (b == hdr) begin
            if (frame_pos == HDR_LEN - 4'd1) xor_acc = '0;
            frame_pos = frame_pos + 4'd1;
         end else begin
            // a stray 0xff may already open the next header
            frame_pos = (b == HDR_BYTE0) ? 4'd1 : 4'd0;
         end
      end else begin
         if (frame_pos == CHECK_START ||
             (frame_pos > CHECK_START && frame_pos < CHECK_END))
            xor_acc = xor_acc ^ b;
         if (frame_pos == CHECK_END)
            xor_acc = xor_acc ^ b;
         case (frame_pos)
            POS_SPEED_A_HI: speed_a[15:8]     = b;
            POS_SPEED_A_LO: speed_a[7:0]      = b;
            POS_SPEED_B_HI: speed_b[15:8]     = b;
            POS_SPEED_B_LO: speed_b[7:0]      = b;
            POS_DIRECTION:  dir_code          = b;
            POS_SERVO_HI:   servo_angle[15:8] = b;
            POS_SERVO_LO:   servo_angle[7:0]  = b;
            default: ;
         endcase
         if (frame_pos == LAST_POS) begin
            res = '0;
            if (xor_acc == 8'h00) begin
               if (dir_code == DIR_FORWARD)
                  motion = MOTION_FORWARD;
               else if (dir_code == DIR_REVERSE)
                  motion = MOTION_REVERSE;
               else
                  motion = MOTION_STOP;
               res.ok           = 1'b1;
               res.motion       = motion;
               res.left_mms     = signed_with_direction(speed_a, motion);
               res.right_mms    = signed_with_direction(speed_b, motion);
               res.sum_half_mms = {res.left_mms[15], res.left_mms} +
                                  {res.right_mms[15], res.right_mms};
               res.servo        = servo_angle;
            end
            expected_frames.push_back(res);
            frame_pos = '0;
         end else begin
            frame_pos = frame_pos + 4'd1;
         end
      end
   endtask

   task automatic compare_result();
      wheel_result_type want;
      if (expected_frames.size() == 0) begin
         report_mismatch("result without a completed frame", 1, 0);
      end else begin
         want = expected_frames.pop_front();
         if (rsp_frame_ok !== want.ok)
            report_mismatch("frame_ok", int'(rsp_frame_ok), int'(want.ok));
         if (rsp_left_speed !== want.left_mms)
            report_mismatch("left_speed", int'(rsp_left_speed),
                            int'($signed(want.left_mms)));
         if (rsp_right_speed !== want.right_mms)
            report_mismatch("right_speed", int'(rsp_right_speed),
                            int'($signed(want.right_mms)));
         if (rsp_linear_speed_sum !== want.sum_half_mms)
            report_mismatch("linear_speed_sum", int'(rsp_linear_speed_sum),
                            int'($signed(want.sum_half_mms)));
         if (rsp_servo_angle_raw !== want.servo)
            report_mismatch("servo_angle_raw", int'(rsp_servo_angle_raw),
                            int'(want.servo));
         if (rsp_motion !== want.motion)
            report_mismatch("motion", int'(rsp_motion), int'(want.motion));
         checked++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_pos   = '0;
         xor_acc     = '0;
         speed_a     = '0;
         speed_b     = '0;
         dir_code    = '0;
         servo_angle = '0;
         expected_frames.delete();
      end else begin
         // a result always trails its last byte, so the order here is free
         if (rsp_valid && !rsp_stall) compare_result();
         if (req_valid && !req_stall) predict_byte(req_rx_byte);
      end
      outstanding = expected_frames.size();
   end

endmodule

>>> bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// byte stream stimulus for the wheel speed frame decoder: directed frames for
// the direction codes, speed extremes, failed checks and header restarts, then
// a long run of random frames mixed with noise and broken headers, with random
// gaps on the byte side and random stalls on the result side
// ---------------------------------------------------------------------------
module testbench;
   import wsfd_pkg::*;

   localparam int LIMIT_CYCLES = 250000;   // slowest legal run stays far below
   localparam int TARGET_BYTES = 1350;
   localparam int DRAIN_CYCLES = 8;        // extra settling after the final drain

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_stall   = 1'b0;
   logic               req_stall;
   logic               rsp_valid;
   logic               rsp_frame_ok;
   logic signed [15:0] rsp_left_speed;
   logic signed [15:0] rsp_right_speed;
   logic signed [16:0] rsp_linear_speed_sum;
   logic [15:0]        rsp_servo_angle_raw;
   logic [1:0]         rsp_motion;

   int mismatch_count;
   int frames_pending;
   int frames_checked;

   int cycle_count = 0;
   int bytes_sent  = 0;
   int stall_left  = 0;
   int stall_roll  = 0;
   bit quiet       = 1'b0;   // stretch with no new gaps or stalls on either side
   bit drained_mid = 1'b0;

   always #4 clock = ~clock;

   wheel_speed_frame_decoder_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_frame_ok         (rsp_frame_ok),
      .rsp_left_speed       (rsp_left_speed),
      .rsp_right_speed      (rsp_right_speed),
      .rsp_linear_speed_sum (rsp_linear_speed_sum),
      .rsp_servo_angle_raw  (rsp_servo_angle_raw),
      .rsp_motion           (rsp_motion)
   );

   wheel_frame_checker frame_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_frame_ok         (rsp_frame_ok),
      .rsp_left_speed       (rsp_left_speed),
      .rsp_right_speed      (rsp_right_speed),
      .rsp_linear_speed_sum (rsp_linear_speed_sum),
      .rsp_servo_angle_raw  (rsp_servo_angle_raw),
      .rsp_motion           (rsp_motion),
      .mismatch_count       (mismatch_count),
      .frames_pending       (frames_pending),
      .frames_checked       (frames_checked)
   );

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("watchdog expired after %0d cycles, %0d frames still pending",
                  cycle_count, frames_pending);
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side backpressure: mostly free, short stalls, now and then a long one
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (quiet) begin
         rsp_stall  <= 1'b0;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 70) begin
            rsp_stall <= 1'b0;
         end else if (stall_roll < 95) begin
            stall_left <= $urandom_range(0, 2);
            rsp_stall  <= 1'b1;
         end else begin
            stall_left <= $urandom_range(8, 30);
            rsp_stall  <= 1'b1;
         end
      end
   end

   // idle cycles before a byte: mostly none, some short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // speeds lean on the signed extremes
   function automatic logic [15:0] pick_speed();
      logic [15:0] v;
      case ($urandom_range(0, 7))
         0:       v = 16'h8000;
         1:       v = 16'h7FFF;
         2:       v = 16'hFFFF;
         3:       v = 16'h0000;
         4:       v = 16'h0001;
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic [7:0] pick_direction();
      logic [7:0] d;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: d = DIR_FORWARD;
         4, 5, 6, 7: d = DIR_REVERSE;
         8:          d = 8'h00;
         default:    d = 8'($urandom);
      endcase
      return d;
   endfunction

   // one byte transfer; valid stays high across back-to-back bytes
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   // full 16-byte frame with a correct xor byte, optionally with one bit flipped
   task automatic send_frame(input logic [15:0] speed_a, input logic [15:0] speed_b,
                             input logic [7:0] direction, input logic [15:0] servo,
                             input bit corrupt);
      logic [7:0] fb [16];
      logic [7:0] check;
      int         i;
      fb[0] = HDR_BYTE0;
      fb[1] = HDR_BYTE1;
      fb[2] = HDR_BYTE2;
      for (i = 3; i < 16; i++) fb[i] = 8'($urandom);
      fb[POS_SPEED_A_HI] = speed_a[15:8];
      fb[POS_SPEED_A_LO] = speed_a[7:0];
      fb[POS_SPEED_B_HI] = speed_b[15:8];
      fb[POS_SPEED_B_LO] = speed_b[7:0];
      fb[POS_DIRECTION]  = direction;
      fb[POS_SERVO_HI]   = servo[15:8];
      fb[POS_SERVO_LO]   = servo[7:0];
      check = '0;
      for (i = CHECK_START; i < CHECK_END; i++) check = check ^ fb[i];
      fb[CHECK_END] = check;
      if (corrupt) begin
         i = $urandom_range(CHECK_START, LAST_POS);
         fb[i] = fb[i] ^ (8'd1 << $urandom_range(0, 7));
      end
      for (i = 0; i < 16; i++) send_byte(fb[i]);
   endtask

   // hold the byte side until every completed frame has produced its result
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);
   endtask

   initial begin
      int roll;
      int n;
      int k;
      logic [7:0] junk;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: signed extremes forward, sum goes negative
      send_frame(16'h7FFF, 16'h8000, DIR_FORWARD, 16'd9000, 1'b0);
      // reverse of the most negative speed saturates
      send_frame(16'h8000, 16'h7FFF, DIR_REVERSE, 16'hFFFF, 1'b0);
      send_frame(16'hFFFF, 16'h0001, DIR_REVERSE, 16'h0000, 1'b0);
      // stop code and an unknown code both give zero speeds
      send_frame(16'h1234, 16'hEDCB, 8'h00, 16'd9000, 1'b0);
      send_frame(16'h8000, 16'h7FFF, 8'hFF, 16'h8001, 1'b0);
      // failed xor check zeroes the whole result
      send_frame(16'h7FFF, 16'h7FFF, DIR_FORWARD, 16'hFFFF, 1'b1);
      // broken header, then a second 0xff that must reopen the hunt
      send_byte(HDR_BYTE0);
      send_byte(HDR_BYTE1);
      send_byte(8'h00);
      send_byte(HDR_BYTE0);
      send_frame(16'h0000, 16'h0000, DIR_FORWARD, 16'h0000, 1'b0);
      // lone tail of a header is just noise
      send_byte(HDR_BYTE1);
      send_byte(HDR_BYTE2);
      send_frame(16'h8000, 16'h8000, DIR_REVERSE, 16'd9000, 1'b0);
      send_frame(16'h8000, 16'h8000, DIR_FORWARD, 16'h5A5A, 1'b0);

      // everything settled before the random part
      drain_results();

      while (bytes_sent < TARGET_BYTES) begin
         quiet <= ($urandom_range(0, 5) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 80) begin
            send_frame(pick_speed(), pick_speed(), pick_direction(),
                       ($urandom_range(0, 3) == 0) ? 16'd9000 : 16'($urandom),
                       ($urandom_range(0, 7) == 0));
         end else if (roll < 90) begin
            // line noise between frames
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) send_byte(8'($urandom));
         end else begin
            // header cut short by a wrong byte
            send_byte(HDR_BYTE0);
            if ($urandom_range(0, 1) == 1) send_byte(HDR_BYTE1);
            junk = 8'($urandom);
            if (junk == HDR_BYTE1 || junk == HDR_BYTE2) junk = 8'h00;
            send_byte(junk);
         end
         // once mid-run the sender waits until the result side has caught up
         if (!drained_mid && bytes_sent > TARGET_BYTES / 2) begin
            drained_mid = 1'b1;
            drain_results();
         end
      end

      quiet <= 1'b0;
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d bytes in random and directed frames, noise and broken headers",
               bytes_sent);
      $display("checked %0d frame results under random gaps and result stalls",
               frames_checked);
      if (mismatch_count == 0 && frames_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/wsfd_pkg.sv
rtl/core/wsfd_frame_parser.sv
rtl/core/wheel_speed_frame_decoder_core.sv
bench/wheel_frame_checker.sv
bench/testbench.sv
